### sv/one_wire_rom_search_macros.svh
// ---------------------------------------------------------------------------
// One-wire ROM search assertion macros
// Concurrent assertion wrappers shared by the ROM search RTL; they compile
// to nothing when ASSERT_OFF is defined.
// ---------------------------------------------------------------------------
`ifndef ONE_WIRE_ROM_SEARCH_MACROS_SVH
`define ONE_WIRE_ROM_SEARCH_MACROS_SVH

`ifndef ASSERT_OFF
// condition holds at every clock edge out of reset
`define OWS_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("ows assertion failed");
// consequent holds in the cycle after the antecedent
`define OWS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ows assertion failed");
`else
`define OWS_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define OWS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### sv/ows_pkg.sv
// ---------------------------------------------------------------------------
// One-wire ROM search package
// Item types, opcodes, status codes and sizing constants for the search.
// ---------------------------------------------------------------------------
`default_nettype none

package ows_pkg;

    // number of independent buses with their own search state
    localparam int NUM_BUSES = 4;
    localparam int BUS_IDX_W = (NUM_BUSES > 1) ? $clog2(NUM_BUSES) : 1;

    localparam int ROM_BITS  = 64;
    localparam int POS_W     = 7;
    localparam int ROM_IDX_W = 6;

    // last ROM position of a pass
    localparam logic [POS_W-1:0] LAST_POS  = 7'(ROM_BITS);
    localparam logic [POS_W-1:0] FIRST_POS = 7'd1;

    typedef logic [BUS_IDX_W-1:0] t_bus_idx;
    typedef logic [POS_W-1:0]     t_pos;
    typedef logic [ROM_BITS-1:0]  t_rom;

    typedef enum logic [1:0] {
        OP_FIRST  = 2'd0,
        OP_NEXT   = 2'd1,
        OP_PAIR   = 2'd2,
        OP_UNUSED = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_SEND     = 3'd0,
        ST_ENDED    = 3'd1,
        ST_BIT      = 3'd2,
        ST_COMPLETE = 3'd3,
        ST_ABORTED  = 3'd4,
        ST_IGNORED  = 3'd5
    } t_status;

    typedef struct packed {
        t_opcode    opcode;
        logic [1:0] bus;
        logic       no_presence;
        logic       id_bit;
        logic       complement_bit;
    } t_in_item;

    typedef struct packed {
        t_status    status;
        logic       write_bit;
        logic       found;
        t_rom       rom_code;
        logic       last_device;
    } t_out_item;

endpackage

`default_nettype wire

### sv/ows_core.sv
// ---------------------------------------------------------------------------
// One-wire ROM search decision core
// Holds per-bus search state and resolves one item per accepted cycle into
// its result: start handling, direction bit choice, abort and end-of-pass update.
// ---------------------------------------------------------------------------
`default_nettype none

`include "one_wire_rom_search_macros.svh"

module ows_core (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_accept,
    input  ows_pkg::t_in_item    i_item,
    output ows_pkg::t_out_item   o_result
);

    // per-bus state
    ows_pkg::t_rom     r_rom       [ows_pkg::NUM_BUSES];
    ows_pkg::t_pos     r_last_disc [ows_pkg::NUM_BUSES];
    logic              r_done      [ows_pkg::NUM_BUSES];

    // running search state
    ows_pkg::t_pos     r_marker;
    ows_pkg::t_pos     r_bit_pos;
    logic              r_active;
    ows_pkg::t_bus_idx r_active_bus;

    ows_pkg::t_pos     n_marker;
    ows_pkg::t_pos     n_bit_pos;
    logic              n_active;
    ows_pkg::t_bus_idx n_active_bus;

    logic              wr_en;
    ows_pkg::t_rom     wr_rom;
    ows_pkg::t_pos     wr_last_disc;
    logic              wr_done;

    logic              is_start;
    logic              bus_ok;
    ows_pkg::t_bus_idx rd_idx;
    ows_pkg::t_rom     cur_rom;
    ows_pkg::t_pos     cur_last_disc;
    logic              cur_done;
    ows_pkg::t_pos     pos_m1;
    ows_pkg::t_rom     bit_mask;
    logic              done_eff;
    logic              dir_bit;
    ows_pkg::t_pos     marker_upd;
    ows_pkg::t_rom     rom_upd;

    // select the bus whose state this item reads and writes
    assign is_start = (i_item.opcode == ows_pkg::OP_FIRST) ||
                      (i_item.opcode == ows_pkg::OP_NEXT);
    assign bus_ok   = (int'(i_item.bus) < ows_pkg::NUM_BUSES);
    assign rd_idx   = (is_start && bus_ok) ? ows_pkg::t_bus_idx'(i_item.bus) : r_active_bus;

    assign cur_rom       = r_rom[rd_idx];
    assign cur_last_disc = r_last_disc[rd_idx];
    assign cur_done      = r_done[rd_idx];

    // bit mask for the current ROM position
    assign pos_m1   = r_bit_pos - ows_pkg::FIRST_POS;
    assign bit_mask = ows_pkg::t_rom'(1) << pos_m1[ows_pkg::ROM_IDX_W-1:0];

    // direction bit: from the pair, or on a conflict from the last discrepancy
    always_comb begin
        if (i_item.id_bit != i_item.complement_bit) begin
            dir_bit = i_item.id_bit;
        end else if (r_bit_pos < cur_last_disc) begin
            dir_bit = |(cur_rom & bit_mask);
        end else begin
            dir_bit = (r_bit_pos == cur_last_disc);
        end
    end

    assign marker_upd = (!i_item.id_bit && !i_item.complement_bit && !dir_bit) ?
                        r_bit_pos : r_marker;
    assign rom_upd    = (cur_rom & ~bit_mask) | (dir_bit ? bit_mask : '0);
    assign done_eff   = (i_item.opcode == ows_pkg::OP_FIRST) ? 1'b0 : cur_done;

    // resolve the item into next state and result
    always_comb begin
        n_marker     = r_marker;
        n_bit_pos    = r_bit_pos;
        n_active     = r_active;
        n_active_bus = r_active_bus;
        wr_en        = 1'b0;
        wr_rom       = cur_rom;
        wr_last_disc = cur_last_disc;
        wr_done      = cur_done;

        o_result.status      = ows_pkg::ST_IGNORED;
        o_result.write_bit   = 1'b0;
        o_result.found       = 1'b0;
        o_result.rom_code    = cur_rom;
        o_result.last_device = cur_done;

        case (i_item.opcode)
            ows_pkg::OP_FIRST, ows_pkg::OP_NEXT: begin
                if (bus_ok) begin
                    n_active_bus = ows_pkg::t_bus_idx'(i_item.bus);
                    wr_en        = 1'b1;
                    wr_done      = done_eff;
                    if (i_item.opcode == ows_pkg::OP_FIRST) begin
                        wr_last_disc = '0;
                    end
                    o_result.last_device = done_eff;
                    if (i_item.no_presence || done_eff) begin
                        wr_last_disc    = '0;
                        n_active        = 1'b0;
                        o_result.status = ows_pkg::ST_ENDED;
                    end else begin
                        n_bit_pos       = ows_pkg::FIRST_POS;
                        n_marker        = '0;
                        n_active        = 1'b1;
                        o_result.status = ows_pkg::ST_SEND;
                    end
                end
            end
            ows_pkg::OP_PAIR: begin
                if (r_active) begin
                    wr_en = 1'b1;
                    if (i_item.id_bit && i_item.complement_bit) begin
                        // no device answered: abort
                        wr_last_disc    = '0;
                        n_active        = 1'b0;
                        o_result.status = ows_pkg::ST_ABORTED;
                    end else begin
                        wr_rom             = rom_upd;
                        n_marker           = marker_upd;
                        o_result.rom_code  = rom_upd;
                        o_result.write_bit = dir_bit;
                        if (r_bit_pos == ows_pkg::LAST_POS) begin
                            wr_last_disc         = marker_upd;
                            wr_done              = (marker_upd == '0);
                            n_active             = 1'b0;
                            n_bit_pos            = ows_pkg::FIRST_POS;
                            o_result.status      = ows_pkg::ST_COMPLETE;
                            o_result.found       = |rom_upd;
                            o_result.last_device = (marker_upd == '0);
                        end else begin
                            n_bit_pos       = r_bit_pos + ows_pkg::FIRST_POS;
                            o_result.status = ows_pkg::ST_BIT;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // hold search state, update on accepted items
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ows_pkg::NUM_BUSES; i++) begin
                r_rom[i]       <= '0;
                r_last_disc[i] <= '0;
                r_done[i]      <= 1'b0;
            end
            r_marker     <= '0;
            r_bit_pos    <= ows_pkg::FIRST_POS;
            r_active     <= 1'b0;
            r_active_bus <= '0;
        end else if (i_accept) begin
            if (wr_en) begin
                r_rom[rd_idx]       <= wr_rom;
                r_last_disc[rd_idx] <= wr_last_disc;
                r_done[rd_idx]      <= wr_done;
            end
            r_marker     <= n_marker;
            r_bit_pos    <= n_bit_pos;
            r_active     <= n_active;
            r_active_bus <= n_active_bus;
        end
    end

    `OWS_ASSERT_ALWAYS(a_pos_range, i_clk, i_rst_n,
        (r_bit_pos != '0) && (r_bit_pos <= ows_pkg::LAST_POS))
    `OWS_ASSERT_ALWAYS(a_marker_behind, i_clk, i_rst_n, !r_active || (r_marker < r_bit_pos))
    `OWS_ASSERT_NEXT(a_complete_disarms, i_clk, i_rst_n,
        i_accept && (o_result.status == ows_pkg::ST_COMPLETE),
        !r_active && (r_bit_pos == ows_pkg::FIRST_POS))

endmodule

`default_nettype wire

### sv/ows_skid.sv
// ---------------------------------------------------------------------------
// One-wire ROM search result buffer
// Two-entry output register with skid stage; decouples the result stall
// from item acceptance.
// ---------------------------------------------------------------------------
`default_nettype none

`include "one_wire_rom_search_macros.svh"

module ows_skid (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  ows_pkg::t_out_item   i_item,
    output logic                 o_full,
    output logic                 o_valid,
    input  wire                  i_stall,
    output ows_pkg::t_out_item   o_item
);

    logic               r_main_valid;
    logic               r_skid_valid;
    ows_pkg::t_out_item r_main;
    ows_pkg::t_out_item r_skid;
    logic               pop;

    assign pop     = r_main_valid && !i_stall;
    assign o_full  = r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_item  = r_main;

    // control: advance the main slot, park in skid when main is held
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= i_push;
            end
        end else if (i_push) begin
            if (r_main_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_main_valid <= 1'b1;
            end
        end
    end

    // payload: move items between slots
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_main <= r_skid_valid ? r_skid : i_item;
        end else if (i_push) begin
            if (r_main_valid) begin
                r_skid <= i_item;
            end else begin
                r_main <= i_item;
            end
        end
    end

    `OWS_ASSERT_ALWAYS(a_skid_needs_main, i_clk, i_rst_n, !r_skid_valid || r_main_valid)
    `OWS_ASSERT_NEXT(a_no_push_when_full, i_clk, i_rst_n, r_skid_valid && !pop, r_skid_valid)

endmodule

`default_nettype wire

### sv/one_wire_rom_search.sv
// ---------------------------------------------------------------------------
// One-wire ROM search engine, top level
// The decision core is combinational; each result is registered into the
// two-entry result buffer, main slot or skid slot while main is held,
// absorbing output stalls. Throughput: one item per cycle unless it is full.
// Reset: synchronous, active low; all buses clear ROM, last discrepancy and
// done flag, the search is disarmed and the result buffer empties.
// ---------------------------------------------------------------------------
`default_nettype none

module one_wire_rom_search (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  ows_pkg::t_in_item    i_in_item,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output ows_pkg::t_out_item   o_out_item
);

    logic               accept;
    logic               buf_full;
    ows_pkg::t_out_item result;

    // take an item whenever the result buffer has room
    assign o_in_stall = buf_full;
    assign accept     = i_in_valid && !buf_full;

    ows_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_in_item),
        .o_result (result)
    );

    ows_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_item  (result),
        .o_full  (buf_full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_item  (o_out_item)
    );

endmodule

`default_nettype wire
